// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/core/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg
// Shared constants, types and helpers of the multichannel PWM scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

   // Sizing
   localparam int CHANNELS  = 32;
   localparam int TIME_BITS = 16;
   localparam int FIELD_W   = 16;
   localparam int LEVEL_W   = 32;
   localparam int CHAN_W    = 5;
   localparam int MODE_W    = 2;

   // Transaction modes
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TIMING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ENABLE = 2'd2;

   // Reset timings, wrapped to the phase width
   localparam logic [TIME_BITS-1:0] RESET_PERIOD = TIME_BITS'(2000);
   localparam logic [TIME_BITS-1:0] RESET_WIDTH  = TIME_BITS'(100);

   typedef logic [TIME_BITS-1:0] time_type;

   // Per-channel command issued for one transaction
   typedef struct packed {
      logic     tick;
      logic     wr_timing;
      logic     wr_enable;
      logic     pwm_on;
      time_type period;
      time_type width;
   } chan_cmd_type;

   // Fit a 16-bit tick count into the phase width (truncate or zero-extend)
   function automatic time_type to_time(input logic [FIELD_W-1:0] v);
      logic [TIME_BITS+FIELD_W-1:0] ext;
      ext = {{TIME_BITS{1'b0}}, v};
      return ext[TIME_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mps_channel.sv -----
// ----------------------------------------------------------------------------
// mps_channel
// State of one PWM channel: settings, latched timings, phase and level.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_channel (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mps_pkg::chan_cmd_type cmd,
   output logic                      level_next
);
   import mps_pkg::*;

   time_type period_setting_ff, period_setting_in;
   time_type width_setting_ff,  width_setting_in;
   logic     enabled_ff,        enabled_in;
   logic     active_ff,         active_in;
   time_type lat_period_ff,     lat_period_in;
   time_type lat_width_ff,      lat_width_in;
   time_type phase_ff,          phase_in;
   logic     level_ff,          level_in;
   time_type phase_inc;

   // Next state for settings writes and ticks
   always_comb begin
      period_setting_in = period_setting_ff;
      width_setting_in  = width_setting_ff;
      enabled_in        = enabled_ff;
      active_in         = active_ff;
      lat_period_in     = lat_period_ff;
      lat_width_in      = lat_width_ff;
      phase_in          = phase_ff;
      level_in          = level_ff;
      phase_inc         = phase_ff + time_type'(1);

      if (cmd.wr_timing) begin
         period_setting_in = cmd.period;
         width_setting_in  = cmd.width;
      end
      if (cmd.wr_enable) begin
         enabled_in = cmd.pwm_on;
      end

      if (cmd.tick) begin
         if (enabled_ff && (!active_ff || phase_inc == lat_period_ff)) begin
            // start of a new period
            active_in     = 1'b1;
            lat_period_in = period_setting_ff;
            lat_width_in  = width_setting_ff;
            phase_in      = '0;
            level_in      = 1'b1;
         end else if (active_ff && phase_inc == lat_width_ff) begin
            level_in = 1'b0;
            phase_in = phase_inc;
         end else if (active_ff && !enabled_ff && phase_inc == lat_period_ff) begin
            // disabled channel ends at the period boundary
            active_in = 1'b0;
            phase_in  = '0;
         end else if (active_ff) begin
            phase_in = phase_inc;
         end
      end
   end

   assign level_next = level_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_setting_ff <= RESET_PERIOD;
         width_setting_ff  <= RESET_WIDTH;
         enabled_ff        <= 1'b0;
         active_ff         <= 1'b0;
         lat_period_ff     <= '0;
         lat_width_ff      <= '0;
         phase_ff          <= '0;
         level_ff          <= 1'b0;
      end else begin
         period_setting_ff <= period_setting_in;
         width_setting_ff  <= width_setting_in;
         enabled_ff        <= enabled_in;
         active_ff         <= active_in;
         lat_period_ff     <= lat_period_in;
         lat_width_ff      <= lat_width_in;
         phase_ff          <= phase_in;
         level_ff          <= level_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/multichannel_pwm_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_pwm_scheduler_top
// Multichannel PWM scheduler: one tick or settings write per transaction.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result is not stalled and returns
// one result per transaction: the request is captured in an input register,
// all channels update in parallel from it as the packed levels land in the
// result register. A stalled result holds the pipe; one more request may wait
// in the input register.
`default_nettype none

module multichannel_pwm_scheduler_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [mps_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [mps_pkg::CHAN_W-1:0]    req_channel,
   input  wire logic                          req_pwm_on,
   input  wire logic [mps_pkg::FIELD_W-1:0]   req_period_ticks,
   input  wire logic [mps_pkg::FIELD_W-1:0]   req_width_ticks,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [mps_pkg::LEVEL_W-1:0]        rsp_levels,
   output logic                               rsp_timing_rejected
);
   import mps_pkg::*;

`include "assert_macros.svh"

   logic                in_valid_ff, in_valid_in;
   logic [MODE_W-1:0]   in_mode_ff;
   logic [CHAN_W-1:0]   in_channel_ff;
   logic                in_pwm_on_ff;
   time_type            in_period_ff;
   time_type            in_width_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_levels_ff;
   logic                rsp_rejected_ff;

   logic                advance;
   logic                fire;
   logic                timing_ok;
   logic                rejected;
   logic                do_tick;
   logic                do_timing;
   logic                do_enable;
   logic [LEVEL_W-1:0]  levels_next;

   // Handshake control
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !advance;
   assign fire        = in_valid_ff && advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff    <= req_mode;
         in_channel_ff <= req_channel;
         in_pwm_on_ff  <= req_pwm_on;
         in_period_ff  <= to_time(req_period_ticks);
         in_width_ff   <= to_time(req_width_ticks);
      end
   end

   // Mode decode
   assign timing_ok = (in_width_ff != '0) && (in_width_ff < in_period_ff);

   always_comb begin
      do_tick   = 1'b0;
      do_timing = 1'b0;
      do_enable = 1'b0;
      rejected  = 1'b0;
      case (in_mode_ff)
         MODE_TICK: begin
            do_tick = fire;
         end
         MODE_TIMING: begin
            do_timing = fire && timing_ok;
            rejected  = !timing_ok;
         end
         MODE_ENABLE: begin
            do_enable = fire;
         end
         default: begin
            do_tick = 1'b0;
         end
      endcase
   end

   // Channel lanes
   genvar c;
   generate
      for (c = 0; c < CHANNELS; c++) begin : g_chan
         chan_cmd_type cmd;
         logic         sel;

         assign sel           = (in_channel_ff == CHAN_W'(c));
         assign cmd.tick      = do_tick;
         assign cmd.wr_timing = do_timing && sel;
         assign cmd.wr_enable = do_enable && sel;
         assign cmd.pwm_on    = in_pwm_on_ff;
         assign cmd.period    = in_period_ff;
         assign cmd.width     = in_width_ff;

         mps_channel u_channel (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .level_next (levels_next[c])
         );
      end
      for (c = CHANNELS; c < LEVEL_W; c++) begin : g_unused
         assign levels_next[c] = 1'b0;
      end
   endgenerate

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_levels_ff   <= levels_next;
         rsp_rejected_ff <= rejected;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_levels          = rsp_levels_ff;
   assign rsp_timing_rejected = rsp_rejected_ff;

   // Checks
   `ASSERT_PROP(a_stall_needs_item, clock, reset, !req_stall || in_valid_ff, "stall with empty input register")
   `ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, rsp_valid_ff, "processed transaction produced no result")
   `ASSERT_NEXT(a_reject_only_timing, clock, reset, fire && (in_mode_ff != MODE_TIMING), !rsp_rejected_ff, "reject flagged on non-timing transaction")

endmodule

`default_nettype wire
